// ----- hw/rtl/pmd_pkg.sv -----
// Package for the PS/2 mouse packet decoder.
// Holds the event codes, the sign bit positions and the packet event record.
// No dependencies.
package pmd_pkg;

  localparam int PKT_BYTES  = 3;
  localparam int POS_W      = $clog2(PKT_BYTES + 1);
  localparam int SIGN_X_BIT = 4;
  localparam int SIGN_Y_BIT = 5;
  localparam int BTN_LEFT_BIT  = 0;
  localparam int BTN_RIGHT_BIT = 1;

  localparam logic KIND_MOTION = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  localparam logic BTN_LEFT  = 1'b0;
  localparam logic BTN_RIGHT = 1'b1;

  typedef struct packed {
    logic              motion;
    logic              left_chg;
    logic              right_chg;
    logic              left_down;
    logic              right_down;
    logic signed [7:0] move_x;
    logic signed [8:0] move_y;
  } evt_set_t;

endpackage

// ----- hw/rtl/pmd_if.sv -----
// Handshake channels of the PS/2 mouse packet decoder.
// Input byte channel and result event channel; no dependencies.
interface pmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] mouse_byte;

  modport source (output valid, output mouse_byte, input ready);
  modport sink   (input valid, input mouse_byte, output ready);
endinterface

interface pmd_out_if;
  logic              valid;
  logic              ready;
  logic              event_kind;
  logic signed [7:0] move_x;
  logic signed [8:0] move_y;
  logic              button_index;
  logic              button_down;
  logic              last_event;

  modport source (output valid, output event_kind, output move_x, output move_y,
                  output button_index, output button_down, output last_event,
                  input ready);
  modport sink   (input valid, input event_kind, input move_x, input move_y,
                  input button_index, input button_down, input last_event,
                  output ready);
endinterface

// ----- hw/rtl/ps2_mouse_packet_decoder_unit.sv -----
// Top level of the PS/2 mouse packet decoder.
// Instantiates pmd_decode and pmd_emit; depends on pmd_pkg and pmd_if.
//
// Takes one mouse byte per cycle. The first two bytes of a packet are only
// stored; the third byte is decoded in the cycle it is accepted and yields
// up to three events (motion, left button, right button), which leave one per
// cycle while the output is not stalled, through a pending register and the
// output register. A third byte waits only while events of the previous
// packet other than the one being issued are still pending.
module ps2_mouse_packet_decoder_unit (
  input logic       clk,
  input logic       rst_n,
  pmd_in_if.sink    in_ch,
  pmd_out_if.source out_ch
);

  pmd_pkg::evt_set_t evts;
  logic              pkt_load;
  logic              take_ok;

  pmd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.mouse_byte),
    .in_ready (in_ch.ready),
    .take_ok  (take_ok),
    .pkt_load (pkt_load),
    .evts     (evts)
  );

  pmd_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .pkt_load         (pkt_load),
    .evts             (evts),
    .take_ok          (take_ok),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_event_kind   (out_ch.event_kind),
    .out_move_x       (out_ch.move_x),
    .out_move_y       (out_ch.move_y),
    .out_button_index (out_ch.button_index),
    .out_button_down  (out_ch.button_down),
    .out_last_event   (out_ch.last_event)
  );

endmodule

// ----- hw/rtl/pmd_decode.sv -----
// Byte gathering and packet decode for the PS/2 mouse packet decoder.
// Keeps packet position, held bytes and button state; depends on pmd_pkg.
module pmd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  output logic              in_ready,
  input  logic              take_ok,
  output logic              pkt_load,
  output pmd_pkg::evt_set_t evts
);

  logic [pmd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                held_r [2];
  logic [1:0]                btn_r, btn_nxt;
  logic                      acc;
  logic                      last_byte;
  logic [7:0]                head;
  logic [8:0]                dx, dy, sum_x, sum_y, half_x, half_y;

  assign last_byte = pos_r[1];
  assign in_ready  = !last_byte || take_ok;
  assign acc       = in_valid && in_ready;
  assign pkt_load  = acc && last_byte;
  assign head      = held_r[0];

  assign dx     = {head[pmd_pkg::SIGN_X_BIT], held_r[1]};
  assign dy     = {head[pmd_pkg::SIGN_Y_BIT], in_byte};
  assign sum_x  = dx + {8'd0, dx[8]};
  assign sum_y  = dy + {8'd0, dy[8]};
  assign half_x = {sum_x[8], sum_x[8:1]};
  assign half_y = {sum_y[8], sum_y[8:1]};

  always_comb begin
    evts.motion     = (dx != 9'd0) || (dy != 9'd0);
    evts.left_chg   = head[pmd_pkg::BTN_LEFT_BIT] != btn_r[0];
    evts.right_chg  = head[pmd_pkg::BTN_RIGHT_BIT] != btn_r[1];
    evts.left_down  = head[pmd_pkg::BTN_LEFT_BIT];
    evts.right_down = head[pmd_pkg::BTN_RIGHT_BIT];
    evts.move_x     = half_x[7:0];
    evts.move_y     = 9'(~half_y + 9'd1);
  end

  always_comb begin
    pos_nxt = pos_r;
    btn_nxt = btn_r;
    if (acc) begin
      if (last_byte) begin
        pos_nxt = '0;
        btn_nxt = {head[pmd_pkg::BTN_RIGHT_BIT], head[pmd_pkg::BTN_LEFT_BIT]};
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      btn_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      btn_r <= btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !last_byte) begin
      held_r[pos_r[0]] <= in_byte;
    end
  end

endmodule

// ----- hw/rtl/pmd_emit.sv -----
// Event queue and result register for the PS/2 mouse packet decoder.
// Holds a packet's pending events, issues one per cycle unless stalled; needs pmd_pkg.
module pmd_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pkt_load,
  input  pmd_pkg::evt_set_t evts,
  output logic              take_ok,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_event_kind,
  output logic signed [7:0] out_move_x,
  output logic signed [8:0] out_move_y,
  output logic              out_button_index,
  output logic              out_button_down,
  output logic              out_last_event
);

  logic [2:0]        pend_r, pend_nxt, rem;
  logic signed [7:0] px_r;
  logic signed [8:0] py_r;
  logic [1:0]        pdn_r;
  logic              load_out;
  logic              issue;

  logic              valid_r, valid_nxt;
  logic              kind_r, kind_nxt;
  logic signed [7:0] mx_r, mx_nxt;
  logic signed [8:0] my_r, my_nxt;
  logic              idx_r, idx_nxt;
  logic              dn_r, dn_nxt;
  logic              last_r, last_nxt;

  assign load_out = !valid_r || out_ready;
  assign issue    = load_out && (pend_r != 3'd0);

  always_comb begin
    rem      = pend_r;
    kind_nxt = pmd_pkg::KIND_MOTION;
    mx_nxt   = '0;
    my_nxt   = '0;
    idx_nxt  = pmd_pkg::BTN_LEFT;
    dn_nxt   = 1'b0;
    if (issue) begin
      priority if (pend_r[0]) begin
        rem[0] = 1'b0;
        mx_nxt = px_r;
        my_nxt = py_r;
      end else if (pend_r[1]) begin
        rem[1]   = 1'b0;
        kind_nxt = pmd_pkg::KIND_BUTTON;
        dn_nxt   = pdn_r[0];
      end else begin
        rem[2]   = 1'b0;
        kind_nxt = pmd_pkg::KIND_BUTTON;
        idx_nxt  = pmd_pkg::BTN_RIGHT;
        dn_nxt   = pdn_r[1];
      end
    end
    last_nxt  = (rem == 3'd0);
    valid_nxt = issue || (valid_r && !out_ready);
    pend_nxt  = pkt_load ? {evts.right_chg, evts.left_chg, evts.motion} : rem;
  end

  assign take_ok = (rem == 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_load) begin
      px_r  <= evts.move_x;
      py_r  <= evts.move_y;
      pdn_r <= {evts.right_down, evts.left_down};
    end
    if (issue) begin
      kind_r <= kind_nxt;
      mx_r   <= mx_nxt;
      my_r   <= my_nxt;
      idx_r  <= idx_nxt;
      dn_r   <= dn_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_event_kind   = kind_r;
  assign out_move_x       = mx_r;
  assign out_move_y       = my_r;
  assign out_button_index = idx_r;
  assign out_button_down  = dn_r;
  assign out_last_event   = last_r;

endmodule

// ----- hw/rtl/pmd_checker.sv -----
// Port checker for the PS/2 mouse packet decoder, bound to the top level.
// Depends on pmd_pkg and ps2_mouse_packet_decoder_unit.
module pmd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              event_kind,
  input logic signed [7:0] move_x,
  input logic signed [8:0] move_y,
  input logic              button_index,
  input logic              button_down,
  input logic              last_event
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(move_x)
      && $stable(move_y) && $stable(button_index) && $stable(button_down)
      && $stable(last_event))
    else $error("stalled result changed");

  a_packet_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_event |=> out_valid)
    else $error("packet events not issued back to back");

  a_button_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind == pmd_pkg::KIND_BUTTON && last_event
      |-> move_x == 8'sd0 && move_y == 9'sd0)
    else $error("button event carries motion");

endmodule

bind ps2_mouse_packet_decoder_unit pmd_checker u_pmd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_kind   (out_ch.event_kind),
  .move_x       (out_ch.move_x),
  .move_y       (out_ch.move_y),
  .button_index (out_ch.button_index),
  .button_down  (out_ch.button_down),
  .last_event   (out_ch.last_event)
);

// ----- tb/sv/ps2_mouse_packet_decoder_unit_test.sv -----
// Self-checking bench for ps2_mouse_packet_decoder_unit: streams mouse packets
// through the byte channel and scores every decoded event against a local decoder.
// Depends on pmd_pkg, pmd_if and the unit's RTL.
module ps2_mouse_packet_decoder_unit_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_OFF_LEN   = 80;

  typedef struct packed {
    logic              kind;
    logic signed [7:0] mx;
    logic signed [8:0] my;
    logic              idx;
    logic              down;
    logic              last;
  } mouse_evt_t;

  logic clk = 1'b0;
  logic rst_n;

  pmd_in_if  in_ch ();
  pmd_out_if out_ch ();

  ps2_mouse_packet_decoder_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  logic [7:0]                tx_bytes[$];
  mouse_evt_t                expected_events[$];
  logic [7:0]                pkt_bytes[2];
  logic [pmd_pkg::POS_W-1:0] pkt_pos;
  logic                      btn_state[2];
  int                        send_idle_pct;
  int                        recv_idle_pct;
  logic                      recv_hold;
  logic                      in_took;
  int                        errors;
  int                        idle_cycles;

  task automatic decode_mouse_byte(input logic [7:0] b);
    mouse_evt_t evts[$];
    mouse_evt_t e;
    logic [7:0] head;
    logic       now_down;
    int         dx;
    int         dy;
    if (pkt_pos < 2) begin
      pkt_bytes[pkt_pos[0]] = b;
      pkt_pos = pkt_pos + 1'b1;
      return;
    end
    pkt_pos = '0;
    head = pkt_bytes[0];
    dx = int'(pkt_bytes[1]) - (head[pmd_pkg::SIGN_X_BIT] ? 256 : 0);
    dy = int'(b) - (head[pmd_pkg::SIGN_Y_BIT] ? 256 : 0);
    if (dx != 0 || dy != 0) begin
      e = '0;
      e.kind = pmd_pkg::KIND_MOTION;
      e.mx = 8'(dx / 2);
      e.my = 9'(-(dy / 2));
      evts.push_back(e);
    end
    for (int i = 0; i < 2; i++) begin
      now_down = head[(i == 0) ? pmd_pkg::BTN_LEFT_BIT : pmd_pkg::BTN_RIGHT_BIT];
      if (now_down != btn_state[i]) begin
        btn_state[i] = now_down;
        e = '0;
        e.kind = pmd_pkg::KIND_BUTTON;
        e.idx = (i == 0) ? pmd_pkg::BTN_LEFT : pmd_pkg::BTN_RIGHT;
        e.down = now_down;
        evts.push_back(e);
      end
    end
    if (evts.size() > 0) evts[evts.size() - 1].last = 1'b1;
    foreach (evts[k]) expected_events.push_back(evts[k]);
  endtask

  function automatic int field_bad(string fname, logic signed [31:0] exp_v,
                                   logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  task automatic queue_packet(input logic [7:0] head, input logic [7:0] bx,
                              input logic [7:0] by);
    tx_bytes.push_back(head);
    tx_bytes.push_back(bx);
    tx_bytes.push_back(by);
  endtask

  task automatic queue_random_packets(input int count);
    logic [7:0] head;
    logic [7:0] bx;
    logic [7:0] by;
    repeat (count) begin
      head = 8'($urandom);
      bx = 8'($urandom);
      by = 8'($urandom);
      case ($urandom_range(7))
        0: begin
          head[pmd_pkg::SIGN_X_BIT] = 1'b0;
          head[pmd_pkg::SIGN_Y_BIT] = 1'b0;
          bx = 8'h00;
          by = 8'h00;
        end
        1: begin
          bx = head[pmd_pkg::SIGN_X_BIT] ? 8'h00 : 8'hFF;
          by = head[pmd_pkg::SIGN_Y_BIT] ? 8'h00 : 8'hFF;
        end
        default: ;
      endcase
      queue_packet(head, bx, by);
    end
  endtask

  task automatic wait_drained();
    while (tx_bytes.size() > 0 || in_ch.valid || expected_events.size() > 0)
      @(posedge clk);
  endtask

  // byte source: hold an offered byte until its transfer
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_took) begin
        if (tx_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.mouse_byte <= tx_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
          in_ch.mouse_byte <= 8'($urandom);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    mouse_evt_t want;
    int bad;
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none actual kind %0d x %0d y %0d idx %0d",
                 $time, out_ch.event_kind, out_ch.move_x, out_ch.move_y,
                 out_ch.button_index);
        errors++;
      end else begin
        want = expected_events.pop_front();
        bad = field_bad("event_kind", want.kind, out_ch.event_kind)
            + field_bad("move_x", want.mx, out_ch.move_x)
            + field_bad("move_y", want.my, out_ch.move_y)
            + field_bad("button_index", want.idx, out_ch.button_index)
            + field_bad("button_down", want.down, out_ch.button_down)
            + field_bad("last_event", want.last, out_ch.last_event);
        if (bad != 0) errors++;
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) decode_mouse_byte(in_ch.mouse_byte);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (tx_bytes.size() == 0 && !in_ch.valid && expected_events.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mouse_byte = 8'h00;
    out_ch.ready = 1'b0;
    in_took = 1'b0;
    recv_hold = 1'b0;
    errors = 0;
    idle_cycles = 0;
    pkt_pos = '0;
    pkt_bytes[0] = 8'h00;
    pkt_bytes[1] = 8'h00;
    btn_state[0] = 1'b0;
    btn_state[1] = 1'b0;
    send_idle_pct = 26;
    recv_idle_pct = 46;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    queue_packet(8'h08, 8'h00, 8'h00);
    queue_packet(8'h09, 8'h01, 8'h00);
    queue_packet(8'h1B, 8'h00, 8'h01);
    queue_packet(8'h28, 8'h7F, 8'h00);
    queue_packet(8'h38, 8'hFF, 8'hFF);
    queue_packet(8'h3B, 8'h01, 8'hFF);
    queue_packet(8'hF7, 8'h80, 8'h80);
    queue_packet(8'h02, 8'h00, 8'h00);
    wait_drained();

    // hold the receiver off so the unit backs up onto its input
    send_idle_pct = 0;
    recv_hold = 1'b1;
    queue_random_packets(10);
    repeat (HOLD_OFF_LEN) @(posedge clk);
    recv_hold = 1'b0;
    wait_drained();

    send_idle_pct = 26;
    recv_idle_pct = 46;
    queue_random_packets(16);
    wait_drained();

    send_idle_pct = 46;
    recv_idle_pct = 26;
    queue_random_packets(16);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_packets(16);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
